[hdl/tcqe_pkg.sv]
// Shared widths, register indexes and interface types of the coefficient quantizer.
`default_nettype none
package tcqe_pkg;

	// Field widths
	localparam int COEFF_W   = 21;
	localparam int POS_W     = 10;
	localparam int QCOEFF_W  = 23;
	localparam int DQCOEFF_W = 32;
	localparam int EOB_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int PARAM_W   = 15;

	// Arithmetic widths
	localparam int QMAG_W = 21;
	localparam int PROD_W = 36;
	localparam int CLAMP_MAX = 32767;

	localparam int MAX_COEFFS_DEF = 1024;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DC_ROUND   = 3'd0,
		REG_AC_ROUND   = 3'd1,
		REG_DC_QUANT   = 3'd2,
		REG_AC_QUANT   = 3'd3,
		REG_DC_DEQUANT = 3'd4,
		REG_AC_DEQUANT = 3'd5,
		REG_LARGE_BLK  = 3'd6,
		REG_HIGH_BD    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [PARAM_W-1:0] dc_round;
		logic [PARAM_W-1:0] ac_round;
		logic [PARAM_W-1:0] dc_quant;
		logic [PARAM_W-1:0] ac_quant;
		logic [PARAM_W-1:0] dc_dequant;
		logic [PARAM_W-1:0] ac_dequant;
		logic               large_block_mode;
		logic               high_bitdepth;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic prep;
		logic mul_q;
		logic mul_dq;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[hdl/tcqe_cfg.sv]
// Configuration register file of the coefficient quantizer.
`default_nettype none
module tcqe_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tcqe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcqe_pkg::CFG_DATA_W-1:0] cfg_data,
	output tcqe_pkg::cfg_t                      cfg
);

	tcqe_pkg::cfg_t cfg_q;
	tcqe_pkg::cfg_reg_t idx;

	assign cfg_ready = 1'b1;
	assign idx       = tcqe_pkg::cfg_reg_t'(cfg_index);
	assign cfg       = cfg_q;

	// Register writes, one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (idx)
				tcqe_pkg::REG_DC_ROUND:   cfg_q.dc_round         <= cfg_data;
				tcqe_pkg::REG_AC_ROUND:   cfg_q.ac_round         <= cfg_data;
				tcqe_pkg::REG_DC_QUANT:   cfg_q.dc_quant         <= cfg_data;
				tcqe_pkg::REG_AC_QUANT:   cfg_q.ac_quant         <= cfg_data;
				tcqe_pkg::REG_DC_DEQUANT: cfg_q.dc_dequant       <= cfg_data;
				tcqe_pkg::REG_AC_DEQUANT: cfg_q.ac_dequant       <= cfg_data;
				tcqe_pkg::REG_LARGE_BLK:  cfg_q.large_block_mode <= cfg_data[0];
				tcqe_pkg::REG_HIGH_BD:    cfg_q.high_bitdepth    <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/tcqe_ctrl.sv]
// Sequencing state machine of the coefficient quantizer.
`default_nettype none
module tcqe_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tcqe_pkg::dp_status_t status,
	output tcqe_pkg::dp_cmd_t        cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PREP   = 5'b00010,
		ST_MUL_Q  = 5'b00100,
		ST_MUL_DQ = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	// Commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				cmd.mul_q = 1'b1;
				state_d   = ST_MUL_DQ;
			end
			ST_MUL_DQ: begin
				cmd.mul_dq = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[hdl/tcqe_dp.sv]
// Quantize, dequantize and end-of-block datapath of the coefficient quantizer.
`default_nettype none
module tcqe_dp #(
	parameter int MAX_COEFFS = tcqe_pkg::MAX_COEFFS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire tcqe_pkg::cfg_t                        cfg,
	input  wire tcqe_pkg::dp_cmd_t                     cmd,
	output tcqe_pkg::dp_status_t                       status,
	input  wire logic signed [tcqe_pkg::COEFF_W-1:0]   coeff,
	input  wire logic [tcqe_pkg::POS_W-1:0]            coef_pos,
	input  wire logic                                  skip_item,
	input  wire logic                                  last,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [tcqe_pkg::POS_W-1:0]                 out_pos,
	output logic signed [tcqe_pkg::QCOEFF_W-1:0]       qcoeff,
	output logic signed [tcqe_pkg::DQCOEFF_W-1:0]      dqcoeff,
	output logic                                       block_end,
	output logic [tcqe_pkg::EOB_W-1:0]                 eob
);

	localparam int SCAN_W  = $clog2(MAX_COEFFS);
	localparam int CNT_W   = $clog2(MAX_COEFFS + 1);
	localparam int EXT_W   = CNT_W + tcqe_pkg::EOB_W;
	localparam int COEFF_W = tcqe_pkg::COEFF_W;
	localparam int QMAG_W  = tcqe_pkg::QMAG_W;
	localparam int PROD_W  = tcqe_pkg::PROD_W;
	localparam int PARAM_W = tcqe_pkg::PARAM_W;

	// Captured item
	logic signed [COEFF_W-1:0]       coeff_q;
	logic [tcqe_pkg::POS_W-1:0]      pos_q;
	logic                            skip_q;
	logic                            last_q;

	// Prepared operands
	logic [COEFF_W-1:0]  t_q;
	logic [PARAM_W-1:0]  qnt_q;
	logic [PARAM_W-1:0]  dqs_q;
	logic                zero_q;
	logic                neg_q;

	// Products
	logic [QMAG_W-1:0]                 qmag_q;
	logic [tcqe_pkg::DQCOEFF_W-1:0]    dmag_q;

	// Block tracking
	logic [SCAN_W-1:0] scan_q;
	logic [CNT_W-1:0]  eob_cnt_q;

	// Output register
	logic                                   out_valid_q;
	logic [tcqe_pkg::POS_W-1:0]             out_pos_q;
	logic signed [tcqe_pkg::QCOEFF_W-1:0]   qcoeff_q;
	logic signed [tcqe_pkg::DQCOEFF_W-1:0]  dqcoeff_q;
	logic                                   block_end_q;
	logic [tcqe_pkg::EOB_W-1:0]             eob_q;

	// Combinational terms
	logic                neg_c;
	logic [COEFF_W-1:0]  mag_c;
	logic                is_ac_c;
	logic [PARAM_W-1:0]  rnd_c;
	logic [PARAM_W-1:0]  rnd_eff_c;
	logic [PARAM_W-1:0]  qnt_c;
	logic [PARAM_W-1:0]  dqs_c;
	logic [COEFF_W-1:0]  sum_c;
	logic [COEFF_W-1:0]  t_c;
	logic                dead_c;
	logic [PROD_W-1:0]   qprod_c;
	logic [QMAG_W-1:0]   qmag_c;
	logic [PROD_W-1:0]   dprod_c;
	logic [CNT_W-1:0]    idx_plus1_c;
	logic [CNT_W-1:0]    eob_val_c;
	logic [EXT_W-1:0]    eob_ext_c;

	assign status.out_free = !out_valid_q || !out_stall;

	// Magnitude, parameter selection, rounding and clamp
	always_comb begin
		neg_c     = coeff_q[COEFF_W-1];
		mag_c     = neg_c ? (COEFF_W'(0) - COEFF_W'(coeff_q)) : COEFF_W'(coeff_q);
		is_ac_c   = (pos_q != '0);
		rnd_c     = is_ac_c ? cfg.ac_round   : cfg.dc_round;
		qnt_c     = is_ac_c ? cfg.ac_quant   : cfg.dc_quant;
		dqs_c     = is_ac_c ? cfg.ac_dequant : cfg.dc_dequant;
		rnd_eff_c = cfg.large_block_mode ?
			PARAM_W'(({1'b0, rnd_c} + (PARAM_W + 1)'(1)) >> 1) : rnd_c;
		sum_c     = mag_c + COEFF_W'(rnd_eff_c);
		t_c       = (!cfg.high_bitdepth && (sum_c > COEFF_W'(tcqe_pkg::CLAMP_MAX))) ?
			COEFF_W'(tcqe_pkg::CLAMP_MAX) : sum_c;
		// in large block mode, dead zone below a quarter of the dequant step
		dead_c    = cfg.large_block_mode && (mag_c < COEFF_W'(dqs_c >> 2));
	end

	// Quantizer multiply and shift
	assign qprod_c = PROD_W'(t_q) * PROD_W'(qnt_q);
	assign qmag_c  = cfg.large_block_mode ? qprod_c[PROD_W-1:15] : QMAG_W'(qprod_c[PROD_W-1:16]);

	// Dequantizer multiply
	assign dprod_c = PROD_W'(qmag_q) * PROD_W'(dqs_q);

	// End-of-block value for this item
	assign idx_plus1_c = CNT_W'(scan_q) + CNT_W'(1);
	assign eob_val_c   = (qmag_q != '0) ? idx_plus1_c : eob_cnt_q;
	assign eob_ext_c   = EXT_W'(eob_val_c);

	// Item capture and operand registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			coeff_q <= coeff;
			pos_q   <= coef_pos;
			skip_q  <= skip_item;
			last_q  <= last;
		end
		if (cmd.prep) begin
			t_q    <= t_c;
			qnt_q  <= qnt_c;
			dqs_q  <= dqs_c;
			zero_q <= skip_q || dead_c;
			neg_q  <= neg_c;
		end
		if (cmd.mul_q) begin
			qmag_q <= zero_q ? '0 : qmag_c;
		end
		if (cmd.mul_dq) begin
			dmag_q <= cfg.large_block_mode ? dprod_c[32:1] : dprod_c[31:0];
		end
		if (cmd.emit) begin
			out_pos_q   <= pos_q;
			qcoeff_q    <= neg_q ? (tcqe_pkg::QCOEFF_W'(0) - tcqe_pkg::QCOEFF_W'(qmag_q))
				: tcqe_pkg::QCOEFF_W'(qmag_q);
			dqcoeff_q   <= neg_q ? (tcqe_pkg::DQCOEFF_W'(0) - dmag_q) : dmag_q;
			block_end_q <= last_q;
			eob_q       <= last_q ? eob_ext_c[tcqe_pkg::EOB_W-1:0] : '0;
		end
	end

	// Scan position and last nonzero tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			eob_cnt_q <= '0;
		end else if (cmd.emit) begin
			if (last_q) begin
				scan_q    <= '0;
				eob_cnt_q <= '0;
			end else begin
				eob_cnt_q <= eob_val_c;
				if (scan_q != SCAN_W'(MAX_COEFFS - 1)) begin
					scan_q <= scan_q + SCAN_W'(1);
				end
			end
		end
	end

	// Output valid: set on emit, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos   = out_pos_q;
	assign qcoeff    = qcoeff_q;
	assign dqcoeff   = dqcoeff_q;
	assign block_end = block_end_q;
	assign eob       = eob_q;

endmodule
`default_nettype wire

[hdl/transform_coeff_quantizer_eob.sv]
// Top level of the dead-zone coefficient quantizer with end-of-block reporting.
// The result register loads after the controller walks capture, operand prep, quant multiply,
// dequant multiply and emit; emit waits while the output is stalled. A new item is taken only
// after the current one is emitted.
// Reset clears all configuration registers, the scan position and the eob count.
`default_nettype none
module transform_coeff_quantizer_eob #(
	parameter int MAX_COEFFS = tcqe_pkg::MAX_COEFFS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tcqe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tcqe_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [tcqe_pkg::COEFF_W-1:0]   coeff,
	input  wire logic [tcqe_pkg::POS_W-1:0]            coef_pos,
	input  wire logic                                  skip_item,
	input  wire logic                                  last,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [tcqe_pkg::POS_W-1:0]                 out_pos,
	output logic signed [tcqe_pkg::QCOEFF_W-1:0]       qcoeff,
	output logic signed [tcqe_pkg::DQCOEFF_W-1:0]      dqcoeff,
	output logic                                       block_end,
	output logic [tcqe_pkg::EOB_W-1:0]                 eob
);

	tcqe_pkg::cfg_t       cfg;
	tcqe_pkg::dp_cmd_t    cmd;
	tcqe_pkg::dp_status_t status;

	tcqe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tcqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tcqe_dp #(
		.MAX_COEFFS (MAX_COEFFS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.coeff      (coeff),
		.coef_pos   (coef_pos),
		.skip_item  (skip_item),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_pos    (out_pos),
		.qcoeff     (qcoeff),
		.dqcoeff    (dqcoeff),
		.block_end  (block_end),
		.eob        (eob)
	);

endmodule
`default_nettype wire
